// ----- design/jpeg_unstuffing_bit_reader_unit_defines.svh -----
// Assertion macros used by the bit reader back end RTL.
// No dependencies; files that assert include this header.
`ifndef JPEG_UNSTUFFING_BIT_READER_UNIT_DEFINES_SVH
`define JPEG_UNSTUFFING_BIT_READER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on i_clk, skipped while reset is asserted.
`define JUB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check a property on i_clk, including cycles in reset.
`define JUB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define JUB_ASSERT(lbl, prop, msg)
`define JUB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/jub_pkg.sv -----
// Shared types and constants for the JPEG unstuffing bit reader.
// No dependencies; used by every module of the block.
package jub_pkg;

    localparam int BUFFER_BITS_DEF = 32;
    localparam int MAX_TAKE_DEF    = 16;

    // command field codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status field codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DOUBLE_FF = 3'd3;
    localparam logic [2:0] ST_MARKER    = 3'd4;
    localparam logic [2:0] ST_RESTART   = 3'd5;
    localparam logic [2:0] ST_HALTED    = 3'd6;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] RST_MASK  = 8'hF8;
    localparam logic [7:0] RST_BASE  = 8'hD0;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH_FF,
        OP_PUSH_ZERO,
        OP_PUSH_OTHER,
        OP_TAKE,
        OP_CLEAR
    } t_op;

    // one queued request
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       is_restart;
        logic [4:0] take_count;  // already saturated at MAX_TAKE
    } t_req;

    // queue status toward the top level
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// ----- design/jub_front.sv -----
// Front end: decodes the command and classifies the pushed byte.
// Depends on jub_pkg.
module jub_front #(
    parameter int MAX_TAKE = jub_pkg::MAX_TAKE_DEF
) (
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_data_byte,
    input  logic [4:0]    i_take_count,
    output jub_pkg::t_req o_req
);
    import jub_pkg::*;

    // classify the request
    always_comb begin
        o_req.data_byte  = i_data_byte;
        o_req.is_restart = ((i_data_byte & RST_MASK) == RST_BASE);
        // saturated count never exceeds the 5-bit input
        if (int'(i_take_count) > MAX_TAKE) begin
            o_req.take_count = 5'(MAX_TAKE);
        end else begin
            o_req.take_count = i_take_count;
        end
        case (i_command)
            CMD_PUSH: begin
                if (i_data_byte == BYTE_FF) begin
                    o_req.op = OP_PUSH_FF;
                end else if (i_data_byte == BYTE_ZERO) begin
                    o_req.op = OP_PUSH_ZERO;
                end else begin
                    o_req.op = OP_PUSH_OTHER;
                end
            end
            CMD_TAKE:  o_req.op = OP_TAKE;
            CMD_CLEAR: o_req.op = OP_CLEAR;
            default:   o_req.op = OP_NOP;
        endcase
    end

endmodule

// ----- design/jub_queue.sv -----
// Two-entry request queue between front and back.
// Depends on jub_pkg.
module jub_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jub_pkg::t_req      i_req,
    input  logic               i_pop,
    output jub_pkg::t_req      o_req,
    output jub_pkg::t_q_status o_status
);
    import jub_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_req              = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == 2'd2);
    assign o_status.not_empty = (r_count != 2'd0);

endmodule

// ----- design/jub_back.sv -----
// Back end: bit buffer, unstuffing state and registered result stage.
// Depends on jub_pkg and the assertion macro header.
`include "jpeg_unstuffing_bit_reader_unit_defines.svh"

module jub_back #(
    parameter int BUFFER_BITS = jub_pkg::BUFFER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  jub_pkg::t_req i_req,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [15:0]   o_bits_value,
    output logic [2:0]    o_status,
    output logic [7:0]    o_marker_code,
    output logic [5:0]    o_bits_available,
    output logic [15:0]   o_stuffed_count
);
    import jub_pkg::*;

    localparam int CW = $clog2(BUFFER_BITS + 1);
    localparam int XW = CW + 1;

    // low n bits set
    function automatic logic [BUFFER_BITS-1:0] f_mask(input logic [CW-1:0] n);
        f_mask = {BUFFER_BITS{1'b1}} >> (BUFFER_BITS - int'(n));
    endfunction

    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ff_pending, n_ff_pending;
    logic                   r_halted, n_halted;
    logic [15:0]            r_stuff, n_stuff;
    logic                   r_valid, n_valid;
    logic [15:0]            n_value;
    logic [2:0]             n_status;
    logic [7:0]             n_marker;

    logic [XW-1:0]          cnt_plus8;
    logic                   no_room;
    logic [CW-1:0]          rest;
    logic [BUFFER_BITS-1:0] append_in;
    logic [BUFFER_BITS-1:0] take_val;

    // next request leaves the queue when the result slot frees up
    assign o_pop = i_req_valid && (!r_valid || !i_out_stall);

    // shared datapath pieces
    always_comb begin
        cnt_plus8 = XW'(r_cnt) + XW'(8);
        no_room   = (cnt_plus8 > XW'(BUFFER_BITS));
        rest      = CW'(XW'(r_cnt) - XW'(i_req.take_count));
        append_in = {r_buf[BUFFER_BITS-9:0],
                     (i_req.op == OP_PUSH_ZERO && r_ff_pending) ? BYTE_FF : i_req.data_byte};
        take_val  = (r_buf >> rest) & f_mask(CW'(i_req.take_count));
    end

    // execute one request
    always_comb begin
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_ff_pending = r_ff_pending;
        n_halted     = r_halted;
        n_stuff      = r_stuff;
        n_value      = 16'd0;
        n_status     = ST_OK;
        n_marker     = 8'd0;
        if (r_halted) begin
            n_status = ST_HALTED;
        end else begin
            case (i_req.op)
                OP_PUSH_FF: begin
                    if (r_ff_pending) begin
                        n_status = ST_DOUBLE_FF;
                    end else begin
                        n_ff_pending = 1'b1;
                    end
                end
                OP_PUSH_ZERO, OP_PUSH_OTHER: begin
                    if (r_ff_pending && i_req.op == OP_PUSH_OTHER) begin
                        // marker after 0xFF
                        n_marker = i_req.data_byte;
                        n_status = i_req.is_restart ? ST_RESTART : ST_MARKER;
                    end else if (no_room) begin
                        n_status = ST_FULL;
                    end else begin
                        n_buf = append_in & f_mask(CW'(cnt_plus8));
                        n_cnt = CW'(cnt_plus8);
                        if (r_ff_pending) begin
                            // stuffing byte dropped, 0xFF kept as data
                            n_ff_pending = 1'b0;
                            n_stuff      = r_stuff + 16'd1;
                        end
                    end
                end
                OP_TAKE: begin
                    if (XW'(i_req.take_count) > XW'(r_cnt)) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_value = 16'(take_val);
                        n_buf   = r_buf & f_mask(rest);
                        n_cnt   = rest;
                    end
                end
                OP_CLEAR: begin
                    n_buf = '0;
                    n_cnt = '0;
                end
                default: begin
                end
            endcase
            if (n_status != ST_OK) begin
                n_halted = 1'b1;
            end
        end
        n_valid = o_pop ? 1'b1 : (r_valid && i_out_stall);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '0;
            r_cnt        <= '0;
            r_ff_pending <= 1'b0;
            r_halted     <= 1'b0;
            r_stuff      <= 16'd0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_buf        <= n_buf;
                r_cnt        <= n_cnt;
                r_ff_pending <= n_ff_pending;
                r_halted     <= n_halted;
                r_stuff      <= n_stuff;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_bits_value     <= n_value;
            o_status         <= n_status;
            o_marker_code    <= n_marker;
            o_bits_available <= 6'(n_cnt);
            o_stuffed_count  <= n_stuff;
        end
    end

    assign o_out_valid = r_valid;

    `JUB_ASSERT(a_halt_sticky, r_halted |=> r_halted, "halted cleared without reset")
    `JUB_ASSERT(a_cnt_range, r_cnt <= CW'(BUFFER_BITS), "bit count beyond buffer size")
    `JUB_ASSERT(a_buf_clean, (r_buf & ~f_mask(r_cnt)) == '0, "stale bits above count")
    `JUB_ASSERT(a_err_halts, o_pop |=> (o_status == ST_OK || r_halted), "error did not halt")

endmodule

// ----- design/jpeg_unstuffing_bit_reader_unit.sv -----
// Top level of the JPEG entropy-coded segment bit reader.
// Depends on jub_pkg, jub_front, jub_queue and jub_back.
//
// Accepts one request (push byte, take 0..MAX_TAKE bits, clear) per clock
// while o_in_stall is low and returns exactly one result per request, in
// order. Requests are decoded and go into a two-entry queue; the back end
// pulls one request per cycle when the result side does not stall and
// updates the bit buffer, so the sustained rate is one request per clock
// whenever the result side does not stall. An accepted request is first
// written into the queue; when the back end pops it, its result is
// registered in the result stage and shown on the outputs. A 0xFF followed
// by 0x00 is unstuffed and counted; markers, double 0xFF, buffer overflow
// and underflow halt the block until reset; while halted, every request
// answers the halted status.
module jpeg_unstuffing_bit_reader_unit #(
    parameter int BUFFER_BITS = jub_pkg::BUFFER_BITS_DEF,
    parameter int MAX_TAKE    = jub_pkg::MAX_TAKE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_take_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_bits_value,
    output logic [2:0]  o_status,
    output logic [7:0]  o_marker_code,
    output logic [5:0]  o_bits_available,
    output logic [15:0] o_stuffed_count
);
    import jub_pkg::*;

    t_req      front_req;
    t_req      queue_req;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    // decode
    jub_front #(
        .MAX_TAKE(MAX_TAKE)
    ) u_front (
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_take_count(i_take_count),
        .o_req       (front_req)
    );

    assign o_in_stall = q_status.full;
    assign q_push     = i_in_valid && !q_status.full;

    // request queue
    jub_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .i_pop   (q_pop),
        .o_req   (queue_req),
        .o_status(q_status)
    );

    // execute
    jub_back #(
        .BUFFER_BITS(BUFFER_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (q_status.not_empty),
        .i_req           (queue_req),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bits_value    (o_bits_value),
        .o_status        (o_status),
        .o_marker_code   (o_marker_code),
        .o_bits_available(o_bits_available),
        .o_stuffed_count (o_stuffed_count)
    );

endmodule
